>>> sv/pklru_pkg.sv
// Shared types, widths and codes for the pair-key recency selector.
package pklru_pkg;

    // Field widths fixed by the item and register formats.
    localparam int ACT_W        = 16;
    localparam int ENT_W        = 16;
    localparam int TIME_W       = 32;
    localparam int MODE_W       = 2;
    localparam int CAP_W        = 7;
    localparam int LFSR_W       = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int STEP_CNT_W   = 4;

    // Default sizes handed to the top level.
    localparam int DEF_TABLE_DEPTH    = 64;
    localparam int DEF_MAX_CANDIDATES = 32;

    // Reset values.
    localparam logic [CAP_W-1:0]         CAP_RESET  = 7'd64;
    localparam logic [LFSR_W-1:0]        LFSR_RESET = 16'd1;
    localparam logic [LFSR_W-1:0]        LFSR_TAPS  = 16'hB400;
    localparam logic signed [TIME_W-1:0] INT_MAX    = 32'sh7FFF_FFFF;

    // Item operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_RECORD = 2'd0,
        MODE_SELECT = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_SEED     = 1'b1
    } cfg_idx_t;

    // One stored table entry.
    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [ENT_W-1:0]         entity;
        logic signed [TIME_W-1:0] stamp;
    } entry_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_TRIM,
        ST_APPEND,
        ST_GATHER,
        ST_PICK,
        ST_MOD,
        ST_READ,
        ST_FINISH
    } state_t;

endpackage

>>> sv/pklru_if.sv
// Channel interfaces: item input, result output and configuration writes.
interface pklru_req_if
    import pklru_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ACT_W-1:0]    action_key;
    logic [ENT_W-1:0]    entity_key;
    logic signed [TIME_W-1:0] time_stamp;
    logic                last;

    modport source (output valid, mode, action_key, entity_key, time_stamp, last,
                    input ready);
    modport sink   (input valid, mode, action_key, entity_key, time_stamp, last,
                    output ready);
endinterface

interface pklru_rsp_if
    import pklru_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ENT_W-1:0] chosen_entity;
    logic             from_unused;
    logic             overflow;

    modport source (output valid, chosen_entity, from_unused, overflow, input ready);
    modport sink   (input valid, chosen_entity, from_unused, overflow, output ready);
endinterface

interface pklru_cfg_if
    import pklru_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/pair_key_lru_selector_top.sv
// Recency table keyed by (action, entity) with random least-recent selection.
//
// Items arrive on req. Mode record stores a key with its use time at the young
// end of the table, removing an older copy of the key and evicting the oldest
// entries beyond the capacity. Mode select hands in one candidate entity per
// transfer; the transfer marked last produces one result on rsp. Mode clear
// empties the table and any partly gathered candidate list.
// cfg writes capacity (index 0) and the random seed (index 1); cfg is always
// ready; the user is to write it only while the block is idle (not enforced).
// The table is scanned one entry per cycle through a single read port. When a
// record finds an older copy of the key the scan stops there and the younger
// entries are moved down over it. The last select candidate adds a bit-serial
// modulo of the generator and a list read. Clear and unknown modes are handled
// in the idle state.
// req.ready is low while an item is in work, so one item is handled at a time.
// A finished result waits in an output register; new items are taken while it
// waits, and a further result holds in the sequencer until rsp drains.
// Reset empties the table, sets capacity 64 and loads the generator with 1;
// no clearing pass is needed.
module pair_key_lru_selector_top
    import pklru_pkg::*;
#(
    parameter int TABLE_DEPTH    = DEF_TABLE_DEPTH,
    parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES
) (
    input  logic        clk,
    input  logic        rst_n,
    pklru_req_if.sink   req,
    pklru_rsp_if.source rsp,
    pklru_cfg_if.sink   cfg
);

    localparam int PTR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CIDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CCNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CCNT_W-1:0] MAXC_C  = CCNT_W'(MAX_CANDIDATES);

    // Map a logical offset from the oldest entry to a physical slot.
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W+1:0] sum;
        begin
            sum = (CNT_W+2)'(base) + (CNT_W+2)'(off);
            if (sum >= (CNT_W+2)'(TABLE_DEPTH))
                sum = sum - (CNT_W+2)'(TABLE_DEPTH);
            phys = sum[PTR_W-1:0];
        end
    endfunction

    // Table size limit for a given capacity value.
    function automatic logic [CNT_W-1:0] limit_of(input logic [CAP_W-1:0] cap);
        begin
            if (int'(cap) < TABLE_DEPTH)
                limit_of = CNT_W'(cap);
            else
                limit_of = DEPTH_C;
        end
    endfunction

    // Control state.
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [CAP_W-1:0]         capacity_reg, capacity_next;
    logic [LFSR_W-1:0]        lfsr_reg, lfsr_next;
    logic [CCNT_W-1:0]        unused_cnt_reg, unused_cnt_next;
    logic [CCNT_W-1:0]        tie_cnt_reg, tie_cnt_next;
    logic signed [TIME_W-1:0] oldest_reg, oldest_next;
    logic                     ovf_reg, ovf_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic [STEP_CNT_W-1:0]    step_reg, step_next;

    // Item and work data.
    logic                     rec_reg, rec_next;
    logic                     last_reg, last_next;
    logic [ACT_W-1:0]         act_reg, act_next;
    logic [ENT_W-1:0]         ent_reg, ent_next;
    logic signed [TIME_W-1:0] time_reg, time_next;
    logic                     hit_reg, hit_next;
    logic signed [TIME_W-1:0] hit_time_reg, hit_time_next;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]         rd_lidx_reg, rd_lidx_next;
    logic                     use_unused_reg, use_unused_next;
    logic                     pick_zero_reg, pick_zero_next;
    logic [LFSR_W-1:0]        div_s_reg, div_s_next;
    logic [CCNT_W-1:0]        div_n_reg, div_n_next;
    logic [CCNT_W-1:0]        rem_reg, rem_next;
    logic [ENT_W-1:0]         rsp_ent_reg, rsp_ent_next;
    logic                     rsp_from_reg, rsp_from_next;
    logic                     rsp_ovf_reg, rsp_ovf_next;

    // Memories and their ports.
    entry_t                   table_mem [TABLE_DEPTH];
    logic [ENT_W-1:0]         unused_mem [MAX_CANDIDATES];
    logic [ENT_W-1:0]         tie_mem [MAX_CANDIDATES];
    entry_t                   mem_rd_reg;
    logic                     mem_we, mem_re;
    logic [PTR_W-1:0]         mem_wa, mem_ra;
    entry_t                   mem_wd;
    logic                     un_we, tie_we, lst_re;
    logic [CIDX_W-1:0]        un_wa, tie_wa, lst_ra;
    logic [ENT_W-1:0]         lst_rd_reg;

    // Combinational helpers.
    logic                     key_match;
    logic [CNT_W-1:0]         lim;
    logic [CNT_W-1:0]         cfg_lim;
    logic [LFSR_W-1:0]        lfsr_adv;
    logic [CCNT_W-1:0]        pick_n;
    logic [CCNT_W:0]          trial;

    assign key_match = (mem_rd_reg.action == act_reg) && (mem_rd_reg.entity == ent_reg);
    assign lim       = limit_of(capacity_reg);
    assign cfg_lim   = limit_of(cfg.data[CAP_W-1:0]);
    assign lfsr_adv  = {1'b0, lfsr_reg[LFSR_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign pick_n    = (unused_cnt_reg != '0) ? unused_cnt_reg : tie_cnt_reg;
    assign trial     = {rem_reg, div_s_reg[LFSR_W-1]};

    assign req.ready     = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.chosen_entity = rsp_ent_reg;
    assign rsp.from_unused   = rsp_from_reg;
    assign rsp.overflow      = rsp_ovf_reg;

    // Sequencer: next state, datapath control and memory ports.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        capacity_next   = capacity_reg;
        lfsr_next       = lfsr_reg;
        unused_cnt_next = unused_cnt_reg;
        tie_cnt_next    = tie_cnt_reg;
        oldest_next     = oldest_reg;
        ovf_next        = ovf_reg;
        rd_pend_next    = rd_pend_reg;
        rsp_valid_next  = rsp_valid_reg;
        step_next       = step_reg;
        rec_next        = rec_reg;
        last_next       = last_reg;
        act_next        = act_reg;
        ent_next        = ent_reg;
        time_next       = time_reg;
        hit_next        = hit_reg;
        hit_time_next   = hit_time_reg;
        rd_idx_next     = rd_idx_reg;
        rd_lidx_next    = rd_lidx_reg;
        use_unused_next = use_unused_reg;
        pick_zero_next  = pick_zero_reg;
        div_s_next      = div_s_reg;
        div_n_next      = div_n_reg;
        rem_next        = rem_reg;
        rsp_ent_next    = rsp_ent_reg;
        rsp_from_next   = rsp_from_reg;
        rsp_ovf_next    = rsp_ovf_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wa          = '0;
        mem_ra          = '0;
        mem_wd          = '0;
        un_we           = 1'b0;
        tie_we          = 1'b0;
        lst_re          = 1'b0;
        un_wa           = unused_cnt_reg[CIDX_W-1:0];
        tie_wa          = tie_cnt_reg[CIDX_W-1:0];
        lst_ra          = rem_reg[CIDX_W-1:0];

        // The output register drains on a transfer.
        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next    = req.action_key;
                    ent_next    = req.entity_key;
                    time_next   = req.time_stamp;
                    last_next   = req.last;
                    hit_next    = 1'b0;
                    rd_idx_next = '0;
                    rd_pend_next = 1'b0;
                    unique case (req.mode)
                        MODE_RECORD:
                        begin
                            rec_next   = 1'b1;
                            state_next = ST_SEARCH;
                        end
                        MODE_SELECT:
                        begin
                            rec_next   = 1'b0;
                            state_next = ST_SEARCH;
                        end
                        MODE_CLEAR:
                        begin
                            count_next      = '0;
                            unused_cnt_next = '0;
                            tie_cnt_next    = '0;
                            oldest_next     = INT_MAX;
                            ovf_next        = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Scan the table from the oldest entry, one read per cycle.
            ST_SEARCH:
            begin
                if (rd_pend_reg && key_match)
                begin
                    hit_next      = 1'b1;
                    hit_time_next = mem_rd_reg.stamp;
                    rd_pend_next  = 1'b0;
                    rd_idx_next   = rd_lidx_reg + 1'b1;
                    state_next    = rec_reg ? ST_SHIFT : ST_GATHER;
                end
                else if (!rd_pend_reg && (rd_idx_reg == count_reg))
                begin
                    state_next = rec_reg ? ST_TRIM : ST_GATHER;
                end
                else if (rd_idx_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    mem_ra       = phys(head_reg, rd_idx_reg);
                    rd_pend_next = 1'b1;
                    rd_lidx_next = rd_idx_reg;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
            end

            // Move younger entries down one slot over the removed key.
            ST_SHIFT:
            begin
                if (rd_pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = phys(head_reg, rd_lidx_reg - 1'b1);
                    mem_wd = mem_rd_reg;
                end
                if (rd_idx_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    mem_ra       = phys(head_reg, rd_idx_reg);
                    rd_pend_next = 1'b1;
                    rd_lidx_next = rd_idx_reg;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_TRIM;
                    end
                end
            end

            // Evict the oldest entries so the new one fits.
            ST_TRIM:
            begin
                if (count_reg >= lim)
                begin
                    head_next  = phys(head_reg, count_reg - lim + 1'b1);
                    count_next = lim - 1'b1;
                end
                state_next = ST_APPEND;
            end

            ST_APPEND:
            begin
                mem_we     = 1'b1;
                mem_wa     = phys(head_reg, count_reg);
                mem_wd     = '{action: act_reg, entity: ent_reg, stamp: time_reg};
                count_next = count_reg + 1'b1;
                state_next = ST_IDLE;
            end

            // Add the candidate to the unused or the oldest-time list.
            ST_GATHER:
            begin
                if (!hit_reg)
                begin
                    if (unused_cnt_reg < MAXC_C)
                    begin
                        un_we           = 1'b1;
                        unused_cnt_next = unused_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (hit_time_reg < oldest_reg)
                begin
                    tie_we       = 1'b1;
                    tie_wa       = '0;
                    tie_cnt_next = CCNT_W'(1);
                    oldest_next  = hit_time_reg;
                end
                else if (hit_time_reg == oldest_reg)
                begin
                    if (tie_cnt_reg < MAXC_C)
                    begin
                        tie_we       = 1'b1;
                        tie_cnt_next = tie_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                state_next = last_reg ? ST_PICK : ST_IDLE;
            end

            // Choose the list and start the modulo of the advanced generator.
            ST_PICK:
            begin
                use_unused_next = (unused_cnt_reg != '0);
                if (pick_n == '0)
                begin
                    pick_zero_next = 1'b1;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    pick_zero_next = 1'b0;
                    lfsr_next      = lfsr_adv;
                    div_s_next     = lfsr_adv;
                    div_n_next     = pick_n;
                    rem_next       = '0;
                    step_next      = '0;
                    state_next     = ST_MOD;
                end
            end

            // Restoring remainder, one dividend bit per cycle.
            ST_MOD:
            begin
                if (trial >= {1'b0, div_n_reg})
                    rem_next = CCNT_W'(trial - {1'b0, div_n_reg});
                else
                    rem_next = trial[CCNT_W-1:0];
                div_s_next = {div_s_reg[LFSR_W-2:0], 1'b0};
                step_next  = step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(LFSR_W - 1))
                    state_next = ST_READ;
            end

            ST_READ:
            begin
                lst_re     = 1'b1;
                state_next = ST_FINISH;
            end

            // Load the output register once it is free, then reset the list.
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_ent_next    = pick_zero_reg ? '0 : lst_rd_reg;
                    rsp_from_next   = pick_zero_reg ? 1'b0 : use_unused_reg;
                    rsp_ovf_next    = ovf_reg;
                    unused_cnt_next = '0;
                    tie_cnt_next    = '0;
                    oldest_next     = INT_MAX;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes are to arrive only while idle; the block does not enforce it.
        if (cfg.valid)
        begin
            if (cfg.index == CFG_CAPACITY)
            begin
                if (cfg.data[CAP_W-1:0] != '0)
                begin
                    capacity_next = cfg.data[CAP_W-1:0];
                    if (count_reg > cfg_lim)
                    begin
                        head_next  = phys(head_reg, count_reg - cfg_lim);
                        count_next = cfg_lim;
                    end
                end
            end
            else
            begin
                lfsr_next = (cfg.data != '0) ? cfg.data : LFSR_RESET;
            end
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            head_reg       <= '0;
            capacity_reg   <= CAP_RESET;
            lfsr_reg       <= LFSR_RESET;
            unused_cnt_reg <= '0;
            tie_cnt_reg    <= '0;
            oldest_reg     <= INT_MAX;
            ovf_reg        <= 1'b0;
            rd_pend_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            head_reg       <= head_next;
            capacity_reg   <= capacity_next;
            lfsr_reg       <= lfsr_next;
            unused_cnt_reg <= unused_cnt_next;
            tie_cnt_reg    <= tie_cnt_next;
            oldest_reg     <= oldest_next;
            ovf_reg        <= ovf_next;
            rd_pend_reg    <= rd_pend_next;
            rsp_valid_reg  <= rsp_valid_next;
            step_reg       <= step_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rec_reg        <= rec_next;
        last_reg       <= last_next;
        act_reg        <= act_next;
        ent_reg        <= ent_next;
        time_reg       <= time_next;
        hit_reg        <= hit_next;
        hit_time_reg   <= hit_time_next;
        rd_idx_reg     <= rd_idx_next;
        rd_lidx_reg    <= rd_lidx_next;
        use_unused_reg <= use_unused_next;
        pick_zero_reg  <= pick_zero_next;
        div_s_reg      <= div_s_next;
        div_n_reg      <= div_n_next;
        rem_reg        <= rem_next;
        rsp_ent_reg    <= rsp_ent_next;
        rsp_from_reg   <= rsp_from_next;
        rsp_ovf_reg    <= rsp_ovf_next;
    end

    // Entry table: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_rd_reg <= table_mem[mem_ra];
    end

    // Candidate lists with a shared registered read.
    always_ff @(posedge clk)
    begin
        if (un_we)
            unused_mem[un_wa] <= ent_reg;
        if (tie_we)
            tie_mem[tie_wa] <= ent_reg;
        if (lst_re)
            lst_rd_reg <= use_unused_reg ? unused_mem[lst_ra] : tie_mem[lst_ra];
    end

endmodule

>>> sv/pklru_checker.sv
// Port-level checks for the pair-key recency selector, bound to the top level.
module pklru_port_checks
    import pklru_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic [MODE_W-1:0] req_mode,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [ENT_W-1:0]  rsp_chosen,
    input logic              rsp_from_unused,
    input logic              rsp_overflow,
    input logic              cfg_ready
);

    // A stalled result keeps its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chosen)
            && $stable(rsp_from_unused) && $stable(rsp_overflow))
        else $error("result changed while stalled");

    // Record and select transfers leave the input not ready in the following cycle.
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_mode == MODE_RECORD || req_mode == MODE_SELECT)
            |=> !req_ready)
        else $error("input ready right after a record or select transfer");

    // A new result only comes out of the busy sequencer.
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared while the sequencer was idle");

    // Configuration is never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind pair_key_lru_selector_top pklru_port_checks u_pklru_port_checks (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_mode        (req.mode),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_chosen      (rsp.chosen_entity),
    .rsp_from_unused (rsp.from_unused),
    .rsp_overflow    (rsp.overflow),
    .cfg_ready       (cfg.ready)
);
